@@ src/wpdn_pkg.sv @@
// Package for the wind pixel decode/normalize block: shared types, codes,
// float constants and the half widening, square, add and rounding helpers.
// Used by wpdn_recur and wind_pixel_decode_normalize_core.
package wpdn_pkg;

    localparam logic [1:0]  FMT_HALF   = 2'd0;
    localparam logic [1:0]  FMT_SINGLE = 2'd1;
    localparam int          FMT_W      = 2;

    localparam logic [31:0] F_CANON_NAN = 32'h7FC0_0000;
    localparam logic [31:0] F_INF       = 32'h7F80_0000;
    localparam logic [31:0] F_ONE       = 32'h3F80_0000;
    localparam logic [31:0] F_ZERO      = 32'h0000_0000;
    localparam logic [31:0] F_LEN_MIN   = 32'h3586_37BD;

    typedef enum logic {ROP_SQRT, ROP_DIV} t_rop;

    // unrounded result: value = sig/2^26 * 2^(exp-127), or a ready special
    typedef struct packed {
        logic               spec;
        logic [31:0]        bits;
        logic               sign;
        logic signed [9:0]  exp;
        logic [26:0]        sig;
        logic               sticky;
    } t_pre;

    function automatic logic f_is_nan(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    function automatic logic f_is_inf(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
    endfunction

    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic       s;
        logic [4:0] ex;
        logic [9:0] man;
        logic [3:0] p;
        logic [3:0] sh;
        logic [9:0] mn;
        logic [7:0] e8;
        s   = h[15];
        ex  = h[14:10];
        man = h[9:0];
        p   = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) p = 4'(i);
        end
        sh = 4'd10 - p;
        mn = man << sh;
        e8 = 8'd113 - {4'd0, sh};
        if (ex == 5'd0) begin
            if (man == 10'd0) return {s, 31'd0};
            return {s, e8, mn, 13'd0};
        end
        if (ex == 5'h1F) return {s, 8'hFF, man, 13'd0};
        return {s, 8'({3'd0, ex} + 8'd112), man, 13'd0};
    endfunction

    function automatic t_pre sq_pre(input logic [31:0] v, input logic [47:0] prod);
        t_pre p;
        p = '0;
        if (f_is_nan(v)) begin
            p.spec = 1'b1;
            p.bits = F_CANON_NAN;
        end else if (f_is_inf(v)) begin
            p.spec = 1'b1;
            p.bits = F_INF;
        end else if (v[30:23] == 8'd0) begin
            p.spec = 1'b1;
            p.bits = F_ZERO;
        end else if (prod[47]) begin
            p.exp    = signed'({1'b0, v[30:23], 1'b0}) - 10'sd126;
            p.sig    = prod[47:21];
            p.sticky = |prod[20:0];
        end else begin
            p.exp    = signed'({1'b0, v[30:23], 1'b0}) - 10'sd127;
            p.sig    = prod[46:20];
            p.sticky = |prod[19:0];
        end
        return p;
    endfunction

    // both operands are non-negative
    function automatic t_pre add_pre(input logic [31:0] a, input logic [31:0] b);
        t_pre        p;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [7:0]  eh;
        logic [7:0]  el;
        logic [23:0] mh;
        logic [23:0] ml;
        logic [53:0] w;
        logic [27:0] sum;
        p = '0;
        if (a[30:23] >= b[30:23]) begin
            hi = a;
            lo = b;
        end else begin
            hi = b;
            lo = a;
        end
        eh  = (hi[30:23] == 8'd0) ? 8'd1 : hi[30:23];
        el  = (lo[30:23] == 8'd0) ? 8'd1 : lo[30:23];
        mh  = {hi[30:23] != 8'd0, hi[22:0]};
        ml  = {lo[30:23] != 8'd0, lo[22:0]};
        w   = {ml, 3'd0, 27'd0} >> (eh - el);
        sum = {1'b0, mh, 3'd0} + {1'b0, w[53:27]};
        if (f_is_nan(a) || f_is_nan(b)) begin
            p.spec = 1'b1;
            p.bits = F_CANON_NAN;
        end else if (f_is_inf(a) || f_is_inf(b)) begin
            p.spec = 1'b1;
            p.bits = F_INF;
        end else if (a[30:0] == 31'd0) begin
            p.spec = 1'b1;
            p.bits = b;
        end else if (b[30:0] == 31'd0) begin
            p.spec = 1'b1;
            p.bits = a;
        end else if (sum[27]) begin
            p.exp    = signed'({2'b0, eh}) + 10'sd1;
            p.sig    = sum[27:1];
            p.sticky = sum[0] | (|w[26:0]);
        end else begin
            p.exp    = signed'({2'b0, eh});
            p.sig    = sum[26:0];
            p.sticky = |w[26:0];
        end
        return p;
    endfunction

    // round to nearest even, with gradual underflow and overflow to infinity
    function automatic logic [31:0] round_pack(input t_pre p);
        logic signed [10:0] shs;
        logic [5:0]         shc;
        logic [53:0]        w;
        logic [26:0]        s;
        logic               st;
        logic               up;
        logic [9:0]         base;
        logic [24:0]        qr;
        logic [32:0]        tot;
        shs = 11'sd1 - 11'(p.exp);
        shc = (shs > 11'sd54) ? 6'd54 : shs[5:0];
        w   = {p.sig, 27'd0} >> shc;
        if (p.exp < 10'sd1) begin
            s    = w[53:27];
            st   = p.sticky | (|w[26:0]);
            base = 10'd0;
        end else begin
            s    = p.sig;
            st   = p.sticky;
            base = 10'(p.exp - 10'sd1);
        end
        up  = s[2] & ((|s[1:0]) | st | s[3]);
        qr  = {1'b0, s[26:3]} + {24'd0, up};
        tot = {base, 23'd0} + {8'd0, qr};
        if (p.spec) return p.bits;
        if (p.sig == 27'd0) return {p.sign, 31'd0};
        if (tot >= 33'h0_7F80_0000) return {p.sign, F_INF[30:0]};
        return {p.sign, tot[30:0]};
    endfunction

endpackage

@@ src/wpdn_recur.sv @@
// Shared radix-2 recurrence unit: square root and divide of IEEE singles,
// one result bit per cycle, with a one-bit-per-cycle normalize of subnormals.
// Depends on wpdn_pkg; returns an unrounded t_pre for the top level to round.
module wpdn_recur (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  wpdn_pkg::t_rop  i_op,
    input  logic [31:0]     i_a,
    input  logic [31:0]     i_b,
    output logic            o_done,
    output wpdn_pkg::t_pre  o_pre
);
    import wpdn_pkg::*;

    typedef enum logic [1:0] {R_IDLE, R_NORM, R_ITER, R_FIN} t_rstate;

    t_rstate            r_state;
    t_rop               r_op;
    logic               r_sign;
    logic [23:0]        r_m;
    logic signed [9:0]  r_e;
    logic [7:0]         r_eb;
    logic [23:0]        r_d;
    logic [49:0]        r_rad;
    logic [27:0]        r_rem;
    logic [26:0]        r_q;
    logic [4:0]         r_cnt;
    logic               r_done;
    t_pre               r_pre;

    logic               w_odd;
    logic signed [9:0]  w_eu;
    logic signed [9:0]  w_eb;
    logic [28:0]        w_opa;
    logic [28:0]        w_opb;
    logic [28:0]        w_diff;
    logic               w_ge;
    logic               w_spec;
    t_pre               w_spre;
    t_pre               w_fpre;

    assign w_odd  = ~r_e[0];
    assign w_eu   = r_e - 10'sd127 - signed'({9'd0, w_odd});
    assign w_eb   = signed'({2'b0, r_eb});
    assign w_opa  = (r_op == ROP_SQRT) ? {r_rem[26:0], r_rad[49:48]} : {1'b0, r_rem};
    assign w_opb  = (r_op == ROP_SQRT) ? {2'b0, r_q[24:0], 2'b01} : {5'd0, r_d};
    assign w_diff = w_opa - w_opb;
    assign w_ge   = w_opa >= w_opb;

    assign o_done = r_done;
    assign o_pre  = r_pre;

    // special operands finish at once
    always_comb begin
        w_spre      = '0;
        w_spre.spec = 1'b1;
        w_spec      = 1'b1;
        if (i_op == ROP_SQRT) begin
            priority if (f_is_nan(i_a))   w_spre.bits = F_CANON_NAN;
            else if (i_a[30:0] == 31'd0)  w_spre.bits = i_a;
            else if (i_a[31])             w_spre.bits = F_CANON_NAN;
            else if (f_is_inf(i_a))       w_spre.bits = i_a;
            else                          w_spec      = 1'b0;
        end else begin
            priority if (f_is_nan(i_a) || f_is_nan(i_b)) begin
                w_spre.bits = F_CANON_NAN;
            end else if (f_is_inf(i_b)) begin
                w_spre.bits = f_is_inf(i_a) ? F_CANON_NAN : {i_a[31], 31'd0};
            end else if (f_is_inf(i_a)) begin
                w_spre.bits = {i_a[31], F_INF[30:0]};
            end else if (i_a[30:0] == 31'd0) begin
                w_spre.bits = {i_a[31], 31'd0};
            end else begin
                w_spec = 1'b0;
            end
        end
    end

    always_comb begin
        w_fpre        = '0;
        w_fpre.sticky = |r_rem;
        if (r_op == ROP_SQRT) begin
            w_fpre.exp = r_e;
            w_fpre.sig = {r_q[24:0], 2'b00};
        end else if (r_q[26]) begin
            w_fpre.sign = r_sign;
            w_fpre.exp  = r_e;
            w_fpre.sig  = r_q;
        end else begin
            w_fpre.sign = r_sign;
            w_fpre.exp  = r_e - 10'sd1;
            w_fpre.sig  = {r_q[25:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                R_IDLE: begin
                    r_done <= i_start && w_spec;
                    if (i_start) begin
                        r_op   <= i_op;
                        r_sign <= i_a[31];
                        r_m    <= {i_a[30:23] != 8'd0, i_a[22:0]};
                        r_e    <= (i_a[30:23] == 8'd0) ? 10'sd1 : signed'({2'b0, i_a[30:23]});
                        r_d    <= {1'b1, i_b[22:0]};
                        r_eb   <= i_b[30:23];
                        r_pre  <= w_spre;
                        if (!w_spec) r_state <= R_NORM;
                    end
                end
                R_NORM: begin
                    r_done <= 1'b0;
                    if (!r_m[23]) begin
                        r_m <= {r_m[22:0], 1'b0};
                        r_e <= r_e - 10'sd1;
                    end else begin
                        r_q     <= '0;
                        r_state <= R_ITER;
                        if (r_op == ROP_SQRT) begin
                            r_rad <= w_odd ? {r_m, 1'b0, 25'd0} : {1'b0, r_m, 25'd0};
                            r_e   <= (w_eu >>> 1) + 10'sd127;
                            r_rem <= '0;
                            r_cnt <= 5'd24;
                        end else begin
                            r_e   <= r_e - w_eb + 10'sd127;
                            r_rem <= {4'd0, r_m};
                            r_cnt <= 5'd26;
                        end
                    end
                end
                R_ITER: begin
                    r_done <= 1'b0;
                    r_q    <= {r_q[25:0], w_ge};
                    if (r_op == ROP_SQRT) begin
                        r_rem <= w_ge ? w_diff[27:0] : w_opa[27:0];
                        r_rad <= {r_rad[47:0], 2'b00};
                    end else begin
                        r_rem <= w_ge ? {w_diff[26:0], 1'b0} : {r_rem[26:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) r_state <= R_FIN;
                end
                R_FIN: begin
                    r_pre   <= w_fpre;
                    r_done  <= 1'b1;
                    r_state <= R_IDLE;
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= R_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/wind_pixel_decode_normalize_core.sv @@
// Top level: decodes two texel channels, forms length and unit direction.
// Depends on wpdn_pkg and wpdn_recur (shared root/divide recurrence).
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------
//  input     | i_valid / o_ready    | i_chan_x, i_chan_y
//  output    | o_valid / i_ready    | o_dir_x, o_dir_y, o_strength, o_ok
//  config    | i_cfg_we             | i_cfg_data (pixel format)
//
// Work per item is set by the radix-2 recurrence: 25 root steps, 27 steps per
// divide, plus a normalize step per leading zero of a subnormal single-mode operand.
// Unsupported format: result the cycle after accept. One item at a time; o_ready
// only while idle. Synchronous active-low reset; format resets to half.
module wind_pixel_decode_normalize_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [31:0]                i_chan_x,
    input  logic [31:0]                i_chan_y,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [31:0]                o_dir_x,
    output logic [31:0]                o_dir_y,
    output logic [31:0]                o_strength,
    output logic                       o_ok,
    input  logic                       i_cfg_we,
    input  logic [wpdn_pkg::FMT_W-1:0] i_cfg_data
);
    import wpdn_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_SQX_M, S_SQX_N, S_SQX_R, S_SQY_M, S_SQY_N, S_SQY_R,
        S_ADD, S_ADD_R, S_SQRT_GO, S_SQRT_W, S_SQRT_R, S_CHK,
        S_DIVX_GO, S_DIVX_W, S_DIVX_R, S_DIVY_GO, S_DIVY_W, S_DIVY_R, S_OUT
    } t_state;

    t_state              r_state;
    logic [FMT_W-1:0]    r_fmt;
    logic [31:0]         r_x;
    logic [31:0]         r_y;
    logic [31:0]         r_sqx;
    logic [31:0]         r_sqy;
    logic [31:0]         r_sum;
    logic [31:0]         r_len;
    logic [47:0]         r_prod;
    t_pre                r_pre;
    logic [31:0]         r_ox;
    logic [31:0]         r_oy;
    logic [31:0]         r_str;
    logic                r_ok;

    logic [31:0]         w_sqop;
    logic [23:0]         w_mant;
    logic [31:0]         w_rnd;
    logic                w_start;
    t_rop                w_op;
    logic [31:0]         w_ra;
    logic                w_done;
    t_pre                w_rpre;
    logic                w_len_ok;

    assign w_sqop  = (r_state == S_SQY_M || r_state == S_SQY_N) ? r_y : r_x;
    assign w_mant  = {1'b1, w_sqop[22:0]};
    assign w_rnd   = round_pack(r_pre);
    assign w_start = (r_state == S_SQRT_GO) || (r_state == S_DIVX_GO) ||
                     (r_state == S_DIVY_GO);
    assign w_op    = (r_state == S_SQRT_GO) ? ROP_SQRT : ROP_DIV;
    assign w_ra    = (r_state == S_SQRT_GO) ? r_sum : ((r_state == S_DIVX_GO) ? r_x : r_y);
    assign w_len_ok = !f_is_nan(r_len) && (r_len > F_LEN_MIN);

    wpdn_recur u_recur (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_op    (w_op),
        .i_a     (w_ra),
        .i_b     (r_len),
        .o_done  (w_done),
        .o_pre   (w_rpre)
    );

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = (r_state == S_OUT);
    assign o_dir_x    = r_ox;
    assign o_dir_y    = r_oy;
    assign o_strength = r_str;
    assign o_ok       = r_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fmt   <= FMT_HALF;
        end else begin
            if (i_cfg_we) r_fmt <= i_cfg_data;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        unique case (r_fmt)
                            FMT_HALF: begin
                                r_x     <= widen_half(i_chan_x[15:0]);
                                r_y     <= widen_half(i_chan_y[15:0]);
                                r_state <= S_SQX_M;
                            end
                            FMT_SINGLE: begin
                                r_x     <= i_chan_x;
                                r_y     <= i_chan_y;
                                r_state <= S_SQX_M;
                            end
                            default: begin
                                r_ox    <= F_ONE;
                                r_oy    <= F_ZERO;
                                r_str   <= F_ZERO;
                                r_ok    <= 1'b0;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_SQX_M: begin
                    r_prod  <= {24'd0, w_mant} * {24'd0, w_mant};
                    r_state <= S_SQX_N;
                end
                S_SQX_N: begin
                    r_pre   <= sq_pre(w_sqop, r_prod);
                    r_state <= S_SQX_R;
                end
                S_SQX_R: begin
                    r_sqx   <= w_rnd;
                    r_state <= S_SQY_M;
                end
                S_SQY_M: begin
                    r_prod  <= {24'd0, w_mant} * {24'd0, w_mant};
                    r_state <= S_SQY_N;
                end
                S_SQY_N: begin
                    r_pre   <= sq_pre(w_sqop, r_prod);
                    r_state <= S_SQY_R;
                end
                S_SQY_R: begin
                    r_sqy   <= w_rnd;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_pre   <= add_pre(r_sqx, r_sqy);
                    r_state <= S_ADD_R;
                end
                S_ADD_R: begin
                    r_sum   <= w_rnd;
                    r_state <= S_SQRT_GO;
                end
                S_SQRT_GO: r_state <= S_SQRT_W;
                S_SQRT_W: begin
                    if (w_done) begin
                        r_pre   <= w_rpre;
                        r_state <= S_SQRT_R;
                    end
                end
                S_SQRT_R: begin
                    r_len   <= w_rnd;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_ok <= 1'b1;
                    priority if (f_is_nan(r_len)) r_str <= F_CANON_NAN;
                    else if (r_len > F_ONE)       r_str <= F_ONE;
                    else                          r_str <= r_len;
                    if (w_len_ok) begin
                        r_state <= S_DIVX_GO;
                    end else begin
                        r_ox    <= F_ONE;
                        r_oy    <= F_ZERO;
                        r_state <= S_OUT;
                    end
                end
                S_DIVX_GO: r_state <= S_DIVX_W;
                S_DIVX_W: begin
                    if (w_done) begin
                        r_pre   <= w_rpre;
                        r_state <= S_DIVX_R;
                    end
                end
                S_DIVX_R: begin
                    r_ox    <= w_rnd;
                    r_state <= S_DIVY_GO;
                end
                S_DIVY_GO: r_state <= S_DIVY_W;
                S_DIVY_W: begin
                    if (w_done) begin
                        r_pre   <= w_rpre;
                        r_state <= S_DIVY_R;
                    end
                end
                S_DIVY_R: begin
                    r_oy    <= w_rnd;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("ready and valid high together");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready after accept");

    a_bad_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_dir_x == F_ONE && o_dir_y == F_ZERO &&
                                o_strength == F_ZERO))
        else $error("unsupported format result wrong");

    a_str_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ok) |-> (o_strength <= F_ONE || o_strength == F_CANON_NAN))
        else $error("strength not clamped");

endmodule
